FILE: rtl/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants of the text line canonicalizer
// Character codes, default run store depth, sequencer states and the
// trim-class test used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned TlcRunDepth = 32;

  localparam logic [ByteW-1:0] ChCr  = 8'h0D;
  localparam logic [ByteW-1:0] ChLf  = 8'h0A;
  localparam logic [ByteW-1:0] ChSp  = 8'h20;
  localparam logic [ByteW-1:0] ChTab = 8'h09;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for a word
    ST_LF,     // CR sent, LF still to send
    ST_FLUSH,  // replaying held trim bytes from the run store
    ST_TAIL    // held run done, send the byte that ended it
  } tlc_state_e;

  // Trim class: CR always, space and tab only in strict mode
  function automatic logic is_trim(input logic [ByteW-1:0] b, input logic strict);
    logic res;
    res = (b == ChCr) || (strict && ((b == ChSp) || (b == ChTab)));
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tlc_run_ram.sv
// ----------------------------------------------------------------------------
// tlc_run_ram: run store of held trim bytes
// One write port, one read port with registered read data.
// Read data holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_run_ram
  import tlc_pkg::*;
#(
  parameter int unsigned DEPTH = TlcRunDepth,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [ByteW-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/text_line_canonicalizer.sv
// ----------------------------------------------------------------------------
// text_line_canonicalizer: byte stream to canonical text (CR LF line ends)
// Trailing trim bytes of a line are held in a run store and replayed before the
// next ordinary byte, or dropped at a line feed, end of stream or overflow.
// ----------------------------------------------------------------------------
// Output: a result word made directly from an input word is on the output
//   register in the cycle after that word is accepted; a replayed held byte
//   passes through the store's registered read port before the output register.
// Input: a word is taken only in idle with a free output slot. A line feed
//   holds off input until CR and LF are loaded, an ordinary byte after a held
//   run until the run and that byte are; trim bytes and end of stream output none.
// Reset: asynchronous, active low; clears count, overflow flag, output valid,
//   and sets trim_mode to strict. Run store contents are not cleared.
`default_nettype none

module text_line_canonicalizer
  import tlc_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = TlcRunDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_trim_mode_i,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             end_of_stream_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [ByteW-1:0] out_byte_o,
  output logic                  last_of_run_o,
  output logic                  run_overflow_o
);

  localparam int unsigned IdxW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RUN_DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(RUN_DEPTH);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  tlc_state_e       state_q, state_d;
  logic             trim_mode_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             data_vld_q, data_vld_d;
  logic [ByteW-1:0] hold_q, hold_d;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q, out_ovf_q;

  logic             slot_free, in_acc;
  logic             out_load;
  logic [ByteW-1:0] out_byte_n;
  logic             out_last_n;
  logic             wr_en, rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [ByteW-1:0] rd_data;
  logic [CntW-1:0]  rd_idx_nxt;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && slot_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign rd_idx_nxt  = rd_idx_q + CntOne;

  // Run store; writes happen only on a held trim byte in idle, reads only when a
  // replay starts or while flushing, so no cycle has both a write and a read.
  tlc_run_ram #(
    .DEPTH (RUN_DEPTH),
    .AW    (IdxW)
  ) u_run_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (data_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer: next state and outputs
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    rd_idx_d   = rd_idx_q;
    data_vld_d = data_vld_q;
    hold_d     = hold_q;
    out_load   = 1'b0;
    out_byte_n = data_byte_i;
    out_last_n = 1'b1;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rd_idx_q[IdxW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (end_of_stream_i) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else if (data_byte_i == ChLf) begin
            count_d    = '0;
            out_load   = 1'b1;
            out_byte_n = ChCr;
            out_last_n = 1'b0;
            state_d    = ST_LF;
          end else if (is_trim(data_byte_i, trim_mode_q)) begin
            if (count_q < CntMax) begin
              wr_en   = 1'b1;
              count_d = count_q + CntOne;
            end else begin
              count_d = '0;
              ovf_d   = 1'b1;
            end
          end else if (count_q == '0) begin
            out_load = 1'b1;
          end else begin
            // start replay of the held run at entry 0
            hold_d     = data_byte_i;
            rd_en      = 1'b1;
            rd_addr    = '0;
            rd_idx_d   = '0;
            data_vld_d = 1'b1;
            state_d    = ST_FLUSH;
          end
        end
      end
      ST_LF: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_byte_n = ChLf;
          state_d    = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (data_vld_q && slot_free) begin
          out_load   = 1'b1;
          out_byte_n = rd_data;
          out_last_n = 1'b0;
          if (rd_idx_nxt < count_q) begin
            // fetch the next held byte behind this one
            rd_en      = 1'b1;
            rd_addr    = rd_idx_nxt[IdxW-1:0];
            rd_idx_d   = rd_idx_nxt;
            data_vld_d = 1'b1;
          end else begin
            data_vld_d = 1'b0;
            state_d    = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_byte_n = hold_q;
          count_d    = '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      trim_mode_q <= 1'b1;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      data_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      data_vld_q <= data_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        trim_mode_q <= cfg_trim_mode_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    hold_q   <= hold_d;
    if (out_load) begin
      out_byte_q <= out_byte_n;
      out_last_q <= out_last_n;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_run_o  = out_last_q;
  assign run_overflow_o = out_ovf_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("held run count beyond store depth");

  a_flush_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (count_q != '0) && (rd_idx_q < count_q))
    else $error("replay without a held run");

  a_data_vld_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_vld_q |-> (state_q == ST_FLUSH))
    else $error("read data pending outside replay");

  a_lf_gives_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !end_of_stream_i && (data_byte_i == ChLf)) |=>
      (out_valid_o && (out_byte_o == ChCr) && !last_of_run_o))
    else $error("line feed did not produce CR first");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_stream_i) |=> ((count_q == '0) && !ovf_q))
    else $error("end of stream left state behind");

endmodule

`default_nettype wire

FILE: verif/text_line_canonicalizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_line_canonicalizer_tb: self-checking bench for the line canonicalizer
// A directed table (typed results where they are obvious, predictor elsewhere)
// is followed by random text shaped as lines, trim runs, line feeds and end of
// stream, in both trim modes. Sender bursts and receiver stall patterns vary.
// ----------------------------------------------------------------------------

module text_line_canonicalizer_tb;
  import tlc_pkg::*;

  localparam int RunDepth     = TlcRunDepth;
  localparam int UsePredictor = -1;      // row result comes from the predictor

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
    logic             ovf;
  } canon_word_t;

  typedef enum logic [0:0] {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [ByteW-1:0] data;
    logic             eos;
    int               reps;
    int               n_typed;
    logic [ByteW-1:0] t0;
    logic [ByteW-1:0] t1;
    logic             tovf;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic             cfg_trim_mode_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i;
  logic             end_of_stream_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ByteW-1:0] out_byte_o;
  logic             last_of_run_o;
  logic             run_overflow_o;

  // predictor state
  logic             strict_q;
  logic [ByteW-1:0] held_run [RunDepth];
  int               held_cnt;
  logic             ovf_sticky;

  canon_word_t      step_q [$];     // words caused by the current input word
  canon_word_t      canon_q [$];    // canonical words still to arrive
  canon_word_t      mon_want;
  stim_row_t        dir_rows [$];

  int               errors;
  int               words_in;
  int               burst_left;
  int               gap_max;
  int               rx_cyc;
  logic [7:0]       ready_pat;
  logic             hold_done;

  text_line_canonicalizer #(
    .RUN_DEPTH(RunDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_trim_mode_i(cfg_trim_mode_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .run_overflow_o (run_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("text_line_canonicalizer test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  task automatic push_step(input logic [ByteW-1:0] ch, input logic last);
    canon_word_t w;
    w.ch   = ch;
    w.last = last;
    w.ovf  = ovf_sticky;
    step_q.push_back(w);
  endtask

  task automatic canon_step(input logic [ByteW-1:0] d, input logic eos);
    int i;
    step_q.delete();
    if (eos) begin
      held_cnt   = 0;
      ovf_sticky = 1'b0;
    end else if (d == ChLf) begin
      held_cnt = 0;
      push_step(ChCr, 1'b0);
      push_step(ChLf, 1'b1);
    end else if (d == ChCr || (strict_q && (d == ChSp || d == ChTab))) begin
      if (held_cnt < RunDepth) begin
        held_run[held_cnt] = d;
        held_cnt++;
      end else begin
        // overflowing byte drops the whole run
        held_cnt   = 0;
        ovf_sticky = 1'b1;
      end
    end else begin
      for (i = 0; i < held_cnt; i++) push_step(held_run[i], 1'b0);
      held_cnt = 0;
      push_step(d, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (canon_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word byte=%02h last=%0b ovf=%0b", $time,
                 out_byte_o, last_of_run_o, run_overflow_o);
      end else begin
        mon_want = canon_q.pop_front();
        if (out_byte_o !== mon_want.ch) begin
          errors++;
          $display("%0t: out_byte expected %02h got %02h", $time,
                   mon_want.ch, out_byte_o);
        end
        if (last_of_run_o !== mon_want.last) begin
          errors++;
          $display("%0t: last_of_run expected %0b got %0b", $time,
                   mon_want.last, last_of_run_o);
        end
        if (run_overflow_o !== mon_want.ovf) begin
          errors++;
          $display("%0t: run_overflow expected %0b got %0b", $time,
                   mon_want.ovf, run_overflow_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // Ready follows a repeating random 8-bit pattern that is itself redrawn; one long hold-off
  initial begin
    out_ready_i = 1'b0;
    ready_pat   = 8'hFF;
    rx_cyc      = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_in >= 150) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (rx_cyc % 64 == 0) begin
        ready_pat = $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom);
        if (ready_pat == 8'h00) ready_pat = 8'h01;
      end
      out_ready_i <= rst_ni && ready_pat[rx_cyc % 8];
      rx_cyc++;
    end
  end

  // ---------------------------------------------------------------- sender
  function automatic stim_row_t word_row(input logic [ByteW-1:0] d, input logic eos);
    stim_row_t r;
    r.kind    = ROW_WORD;
    r.data    = d;
    r.eos     = eos;
    r.reps    = 1;
    r.n_typed = UsePredictor;
    r.t0      = '0;
    r.t1      = '0;
    r.tovf    = 1'b0;
    return r;
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [ByteW-1:0] d,
                         input logic eos, input int reps, input int n_typed,
                         input logic [ByteW-1:0] t0, input logic [ByteW-1:0] t1,
                         input logic tovf);
    stim_row_t r;
    r.kind    = kind;
    r.data    = d;
    r.eos     = eos;
    r.reps    = reps;
    r.n_typed = n_typed;
    r.t0      = t0;
    r.t1      = t1;
    r.tovf    = tovf;
    dir_rows.push_back(r);
  endtask

  task automatic send_word(input stim_row_t row);
    int gap;
    canon_word_t w;
    // bursts of random length, separated by random gaps unless gap_max is 0
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max != 0) begin
        gap = $urandom_range(1, gap_max);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    data_byte_i     <= row.data;
    end_of_stream_i <= row.eos;
    do @(posedge clk_i); while (!in_ready_o);
    words_in++;
    canon_step(row.data, row.eos);
    if (row.n_typed == UsePredictor) begin
      foreach (step_q[i]) canon_q.push_back(step_q[i]);
    end else begin
      w.ovf = row.tovf;
      if (row.n_typed == 2) begin
        w.ch   = row.t0;
        w.last = 1'b0;
        canon_q.push_back(w);
        w.ch   = row.t1;
        w.last = 1'b1;
        canon_q.push_back(w);
      end else if (row.n_typed == 1) begin
        w.ch   = row.t0;
        w.last = 1'b1;
        canon_q.push_back(w);
      end
    end
  endtask

  // wait until every expected word is out and the block has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (canon_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_trim_mode(input logic mode);
    wait_idle();
    cfg_valid_i     <= 1'b1;
    cfg_trim_mode_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    strict_q = mode;
  endtask

  function automatic logic [ByteW-1:0] pick_trim();
    case ($urandom_range(0, 2))
      0:       return ChSp;
      1:       return ChTab;
      default: return ChCr;
    endcase
  endfunction

  // random text: mostly lines with trailing runs, some noise
  task automatic send_text(input int target);
    int sent;
    int kind;
    int len;
    int j;
    logic [ByteW-1:0] b;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) begin
          b = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(8'h21, 8'h7E));
          send_word(word_row(b, 1'b0));
        end
      end else if (kind < 75) begin
        // trim run, now and then long enough to overflow the store
        len = $urandom_range(0, 7) == 0 ? $urandom_range(RunDepth - 4, RunDepth + 4)
                                        : $urandom_range(1, 5);
        for (j = 0; j < len; j++) send_word(word_row(pick_trim(), 1'b0));
      end else if (kind < 90) begin
        len = 1;
        send_word(word_row(ChLf, 1'b0));
      end else if (kind < 95) begin
        len = 1;
        send_word(word_row(8'($urandom_range(0, 255)), 1'b1));
      end else begin
        len = 1;
        send_word(word_row(8'($urandom_range(0, 255)), 1'b0));
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_trim_mode_i = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    end_of_stream_i = 1'b0;
    errors          = 0;
    words_in        = 0;
    burst_left      = 0;
    gap_max         = 2;
    strict_q        = 1'b1;
    held_cnt        = 0;
    ovf_sticky      = 1'b0;

    // directed table, strict mode out of reset
    add_row(ROW_WORD, 8'h00, 1'b0, 1, 1, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'hFF, 1'b0, 1, 1, 8'hFF, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h41, 1'b0, 1, 1, 8'h41, 8'h00, 1'b0);
    add_row(ROW_WORD, ChSp,  1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChTab, 1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChCr,  1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h42, 1'b0, 1, UsePredictor, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChSp,  1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChCr,  1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChLf,  1'b0, 1, 2, ChCr, ChLf, 1'b0);
    add_row(ROW_WORD, ChCr,  1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChLf,  1'b0, 1, 2, ChCr, ChLf, 1'b0);
    add_row(ROW_WORD, ChSp,  1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h00, 1'b1, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h43, 1'b0, 1, 1, 8'h43, 8'h00, 1'b0);
    add_row(ROW_WORD, ChLf,  1'b0, 1, 2, ChCr, ChLf, 1'b0);
    add_row(ROW_WORD, 8'hFF, 1'b1, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChLf,  1'b1, 1, 0, 8'h00, 8'h00, 1'b0);
    // full store replayed: the longest result sequence
    add_row(ROW_WORD, ChCr,  1'b0, RunDepth, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h47, 1'b0, 1, UsePredictor, 8'h00, 8'h00, 1'b0);
    // store overflow sets the sticky flag, end of stream clears it
    add_row(ROW_WORD, ChSp,  1'b0, RunDepth, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChTab, 1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h44, 1'b0, 1, 1, 8'h44, 8'h00, 1'b1);
    add_row(ROW_WORD, ChSp,  1'b0, 2, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h45, 1'b0, 1, UsePredictor, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChLf,  1'b0, 1, 2, ChCr, ChLf, 1'b1);
    add_row(ROW_WORD, 8'h00, 1'b1, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h46, 1'b0, 1, 1, 8'h46, 8'h00, 1'b0);
    // relaxed mode: space and tab pass, only CR is held
    add_row(ROW_CFG,  8'h00, 1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChSp,  1'b0, 1, 1, ChSp, 8'h00, 1'b0);
    add_row(ROW_WORD, ChCr,  1'b0, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChTab, 1'b0, 1, UsePredictor, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, ChCr,  1'b0, RunDepth + 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_WORD, 8'h48, 1'b0, 1, 1, 8'h48, 8'h00, 1'b1);
    add_row(ROW_WORD, 8'h00, 1'b1, 1, 0, 8'h00, 8'h00, 1'b0);
    add_row(ROW_CFG,  8'h01, 1'b0, 1, 0, 8'h00, 8'h00, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_trim_mode(dir_rows[r].data[0]);
      end else begin
        repeat (dir_rows[r].reps) send_word(dir_rows[r]);
      end
    end

    // random text over both modes; first phase offers back to back
    for (int ph = 0; ph < 4; ph++) begin
      write_trim_mode(ph % 2 == 1);
      case (ph)
        0:       gap_max = 0;
        1:       gap_max = 3;
        2:       gap_max = 10;
        default: gap_max = 1;
      endcase
      burst_left = 0;
      send_text(45);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("text_line_canonicalizer test passed");
    end else begin
      $display("text_line_canonicalizer test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tlc_pkg.sv
rtl/tlc_run_ram.sv
rtl/text_line_canonicalizer.sv
verif/text_line_canonicalizer_tb.sv
